### rtl/slid_pkg.sv
// Types and constants for the sorted list insert/delete block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package slid_pkg;

  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/slid_if.sv
// Valid/ready channel interfaces for the operation and result beats.
// Depends on slid_pkg for the payload widths.
`default_nettype none

interface slid_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [slid_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slid_out_if;
  logic                          valid;
  logic                          ready;
  logic [slid_pkg::STATUS_W-1:0] status;
  logic [slid_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

### rtl/slid_ctrl.sv
// Controller state machine: takes an operation beat, runs it, hands the result on.
// Depends on slid_pkg for the state and command types.
`default_nettype none

module slid_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output slid_pkg::cmd_t      cmd
);

  slid_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.load   = (state_r == slid_pkg::S_IDLE) && in_valid;
    cmd.commit = (state_r == slid_pkg::S_EXEC) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slid_pkg::S_IDLE: begin
        if (cmd.load) state_nxt = slid_pkg::S_EXEC;
      end
      slid_pkg::S_EXEC: begin
        if (cmd.commit) state_nxt = slid_pkg::S_IDLE;
      end
      default: state_nxt = slid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slid_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == slid_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  a_no_load_and_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit in the same cycle");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == slid_pkg::S_EXEC))
    else $error("accepted beat did not start execution");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

endmodule

`default_nettype wire

### rtl/slid_dp.sv
// Datapath: the ordered register chain, its compare row and the result register.
// Depends on slid_pkg; driven by commands from slid_ctrl.
`default_nettype none

module slid_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire slid_pkg::cmd_t                      cmd,
  input  wire logic                                in_mode,
  input  wire logic [slid_pkg::VALUE_W-1:0]        in_value,
  output logic      [slid_pkg::STATUS_W-1:0]       out_status,
  output logic      [slid_pkg::COUNT_W-1:0]        out_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [slid_pkg::VALUE_W-1:0]  entries_r [DEPTH];
  logic [slid_pkg::VALUE_W-1:0]  entries_nxt [DEPTH];
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          mode_r;
  logic [slid_pkg::VALUE_W-1:0]  value_r;
  logic [slid_pkg::STATUS_W-1:0] status_r;
  slid_pkg::status_t             status_nxt;
  logic [slid_pkg::COUNT_W-1:0]  out_count_r;
  logic [CW+slid_pkg::COUNT_W-1:0] count_ext;

  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] eq;
  logic             full;
  logic             empty;
  logic             found;
  logic             do_ins;
  logic             do_del;

  // Each cell compares itself with the operand; the list is sorted, so the
  // greater-or-equal flags form a thermometer and equal cells are contiguous.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    logic vld;
    assign vld   = CW'(i) < count_r;
    assign ge[i] = vld && (entries_r[i] >= value_r);
    assign eq[i] = vld && (entries_r[i] == value_r);
  end

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign found  = |eq;
  assign do_ins = (mode_r == slid_pkg::MODE_INSERT) && !full;
  assign do_del = (mode_r == slid_pkg::MODE_DELETE) && found;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_ge;
    logic [slid_pkg::VALUE_W-1:0] left_val;
    logic [slid_pkg::VALUE_W-1:0] right_val;
    logic at_end;

    if (i > 0) begin : g_left
      assign prev_ge  = ge[i-1];
      assign left_val = entries_r[i-1];
    end else begin : g_first
      assign prev_ge  = 1'b0;
      assign left_val = entries_r[i];
    end

    if (i < DEPTH - 1) begin : g_right
      assign right_val = entries_r[i+1];
    end else begin : g_last
      assign right_val = entries_r[i];
    end

    assign at_end = (count_r == CW'(i));

    always_comb begin
      entries_nxt[i] = entries_r[i];
      if (do_ins) begin
        if (prev_ge) begin
          entries_nxt[i] = left_val;
        end else if (ge[i] || at_end) begin
          entries_nxt[i] = value_r;
        end
      end else if (do_del) begin
        if (ge[i]) entries_nxt[i] = right_val;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    if (mode_r == slid_pkg::MODE_INSERT) begin
      status_nxt = full ? slid_pkg::ST_FULL : slid_pkg::ST_INSERTED;
    end else if (empty) begin
      status_nxt = slid_pkg::ST_EMPTY;
    end else if (found) begin
      status_nxt = slid_pkg::ST_DELETED;
    end else begin
      status_nxt = slid_pkg::ST_NOT_FOUND;
    end
  end

  assign count_ext = (CW + slid_pkg::COUNT_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
    if (cmd.commit) begin
      for (int k = 0; k < DEPTH; k++) begin
        entries_r[k] <= entries_nxt[k];
      end
      status_r    <= status_nxt;
      out_count_r <= count_ext[slid_pkg::COUNT_W-1:0];
    end
  end

  assign out_status = status_r;
  assign out_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && do_ins) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the list");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && status_nxt == slid_pkg::ST_FULL) |=> $stable(count_r))
    else $error("refused insert changed the count");

  a_delete_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && do_del) |-> (ge != '0))
    else $error("delete found a match outside the thermometer");

endmodule

`default_nettype wire

### rtl/sorted_list_insert_delete.sv
// Top level of the sorted byte list: joins the controller and the datapath.
// Depends on slid_pkg, slid_in_if, slid_out_if, slid_ctrl and slid_dp.
//
//   Channel  Direction  Payload          Beat taken when
//   in_ch    sink       mode, value      in_ch.valid && in_ch.ready
//   out_ch   source     status, count    out_ch.valid && out_ch.ready
//
// An operation first captures the beat; then, in the execute step, every
// cell of the register chain compares against the value and shifts at once.
// A new operation is taken only after the last one has committed its result.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
// A result waiting in the output register stalls only the execute step.
`default_nettype none

module sorted_list_insert_delete #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slid_in_if.sink    in_ch,
  slid_out_if.source out_ch
);

  slid_pkg::cmd_t cmd;

  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  slid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_ch.mode),
    .in_value   (in_ch.value),
    .out_status (out_ch.status),
    .out_count  (out_ch.count)
  );

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the sorted byte list: drives insert and delete beats and checks
// every status and count against an internal model of the ordered list.
// Depends on slid_pkg, slid_in_if, slid_out_if and sorted_list_insert_delete.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int unsigned VALUE_W = slid_pkg::VALUE_W;
  localparam int unsigned COUNT_W = slid_pkg::COUNT_W;

  typedef struct {
    slid_pkg::status_t    status;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  logic clk;
  logic rst_n;

  slid_in_if  in_ch();
  slid_out_if out_ch();

  sorted_list_insert_delete #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VALUE_W-1:0] list_q[$];
  list_result_t       pending_results[$];
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;
  int                 send_idle = 0;
  int                 recv_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic list_result_t apply_op(slid_pkg::mode_t m, logic [VALUE_W-1:0] v);
    list_result_t r;
    int pos;
    pos = 0;
    if (m == slid_pkg::MODE_INSERT) begin
      if (list_q.size() >= DEPTH) begin
        r.status = slid_pkg::ST_FULL;
      end else begin
        while (pos < list_q.size() && v > list_q[pos]) pos++;
        list_q.insert(pos, v);
        r.status = slid_pkg::ST_INSERTED;
      end
    end else begin
      if (list_q.size() == 0) begin
        r.status = slid_pkg::ST_EMPTY;
      end else begin
        while (pos < list_q.size() && list_q[pos] != v) pos++;
        if (pos >= list_q.size()) begin
          r.status = slid_pkg::ST_NOT_FOUND;
        end else begin
          list_q.delete(pos);
          r.status = slid_pkg::ST_DELETED;
        end
      end
    end
    r.count = COUNT_W'(list_q.size());
    return r;
  endfunction

  // Result beats are checked as they are taken; ready is redrawn every cycle.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d count %0d",
               out_ch.status, out_ch.count);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_ch.status);
          err_cnt++;
        end
        if (out_ch.count !== exp_r.count) begin
          $error("count: expected %0d, actual %0d", exp_r.count, out_ch.count);
          err_cnt++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_op(input slid_pkg::mode_t m, input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_op(m, v));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_op(slid_pkg::MODE_DELETE, 8'h00);
    send_op(slid_pkg::MODE_DELETE, 8'hFF);
  endtask

  task automatic test_extremes();
    send_op(slid_pkg::MODE_INSERT, 8'hFF);
    send_op(slid_pkg::MODE_INSERT, 8'h00);
    send_op(slid_pkg::MODE_INSERT, 8'h80);
    send_op(slid_pkg::MODE_INSERT, 8'h7F);
    send_op(slid_pkg::MODE_INSERT, 8'h00);
    send_op(slid_pkg::MODE_INSERT, 8'h55);
    send_op(slid_pkg::MODE_INSERT, 8'hAA);
    send_op(slid_pkg::MODE_DELETE, 8'h01);
    send_op(slid_pkg::MODE_DELETE, 8'h00);
    send_op(slid_pkg::MODE_DELETE, 8'h00);
    send_op(slid_pkg::MODE_DELETE, 8'h00);
    send_op(slid_pkg::MODE_DELETE, 8'hFF);
    send_op(slid_pkg::MODE_DELETE, 8'h80);
    send_op(slid_pkg::MODE_DELETE, 8'h7F);
    send_op(slid_pkg::MODE_DELETE, 8'h55);
    send_op(slid_pkg::MODE_DELETE, 8'hAA);
    send_op(slid_pkg::MODE_DELETE, 8'hAA);
  endtask

  // Fills the list past its depth so that the last inserts are refused,
  // then empties it in random order and deletes once more.
  task automatic test_fill_and_drain();
    int i;
    for (i = 0; i < DEPTH + 2; i++)
      send_op(slid_pkg::MODE_INSERT, VALUE_W'($urandom_range(0, 255)));
    while (list_q.size() != 0)
      send_op(slid_pkg::MODE_DELETE, list_q[$urandom_range(0, list_q.size() - 1)]);
    send_op(slid_pkg::MODE_DELETE, VALUE_W'($urandom_range(0, 255)));
  endtask

  // The fill level drifts towards a target that is redrawn now and then, so
  // the list passes through every count; most deletes name a stored value.
  task automatic test_random_ops(input int n_ops);
    int target;
    int i;
    int r;
    slid_pkg::mode_t m;
    logic [VALUE_W-1:0] v;
    target = $urandom_range(0, DEPTH);
    for (i = 0; i < n_ops; i++) begin
      if ($urandom_range(0, 15) == 0) target = $urandom_range(0, DEPTH + 2);
      r = $urandom_range(0, 99);
      if (list_q.size() < target)
        m = (r < 80) ? slid_pkg::MODE_INSERT : slid_pkg::MODE_DELETE;
      else if (list_q.size() > target)
        m = (r < 80) ? slid_pkg::MODE_DELETE : slid_pkg::MODE_INSERT;
      else
        m = r[0] ? slid_pkg::MODE_DELETE : slid_pkg::MODE_INSERT;
      if (m == slid_pkg::MODE_DELETE && list_q.size() > 0 && $urandom_range(0, 99) < 70)
        v = list_q[$urandom_range(0, list_q.size() - 1)];
      else if ($urandom_range(0, 3) == 0)
        v = VALUE_W'($urandom_range(0, 7)) | (r[1] ? 8'hF8 : 8'h00);
      else
        v = VALUE_W'($urandom_range(0, 255));
      send_op(m, v);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= slid_pkg::MODE_INSERT;
    in_ch.value <= '0;
    send_idle = 27;
    recv_idle = 54;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_extremes();
    test_fill_and_drain();
    test_random_ops(650);
    wait_drained();

    send_idle = 54;
    recv_idle = 27;
    test_fill_and_drain();
    test_random_ops(650);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    test_random_ops(650);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/slid_pkg.sv
rtl/slid_if.sv
rtl/slid_ctrl.sv
rtl/slid_dp.sv
rtl/sorted_list_insert_delete.sv
test/tb.sv
